// ===== design/sitpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sitpd_pkg
// Shared types, constants and the binary-to-BCD step for the signed integer
// to padded decimal text converter.
// ----------------------------------------------------------------------------
package sitpd_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned FWIDTH_W      = 6;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned CNT_W         = 7;
  localparam int unsigned DIGITS        = 10;
  localparam int unsigned DIG_W         = 4;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned DD_STEPS      = 8;
  localparam int unsigned DD_STAGES     = 4;
  localparam int unsigned DEF_MAX_WIDTH = 32;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

  typedef logic [DIGITS-1:0][DIG_W-1:0] bcd_t;

  typedef struct packed {
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
    logic               neg;
    logic [CNT_W-1:0]   width;
  } dd_t;

  typedef struct packed {
    bcd_t             bcd;
    logic             neg;
    logic [DIG_W-1:0] lead;
    logic [CNT_W-1:0] pad;
    logic [CNT_W-1:0] width;
  } fmt_t;

  // One shift-and-add-3 step of the double dabble conversion.
  function automatic dd_t dabble_step(dd_t x);
    dd_t y;
    y = x;
    for (int i = 0; i < DIGITS; i++) begin
      if (y.bcd[i] >= 4'd5) begin
        y.bcd[i] = y.bcd[i] + 4'd3;
      end
    end
    {y.bcd, y.bin} = {y.bcd, y.bin} << 1;
    return y;
  endfunction

endpackage

// ===== design/sitpd_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// sitpd_dabble_stage
// One pipeline stage of the binary-to-BCD converter, doing a fixed number of
// double dabble steps between registers.
// ----------------------------------------------------------------------------
module sitpd_dabble_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sitpd_pkg::dd_t data_i,
  output logic           stall_o,
  output logic           valid_o,
  output sitpd_pkg::dd_t data_o,
  input  logic           stall_i
);
  import sitpd_pkg::*;

  logic valid_q;
  dd_t  data_d;
  dd_t  data_q;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < DD_STEPS; s++) begin
      data_d = dabble_step(data_d);
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/sitpd_format.sv =====
// ----------------------------------------------------------------------------
// sitpd_format
// Pipeline stage that finds the number of significant digits and works out
// the text length and the count of leading pad spaces.
// ----------------------------------------------------------------------------
module sitpd_format (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  sitpd_pkg::dd_t  data_i,
  output logic            stall_o,
  output logic            valid_o,
  output sitpd_pkg::fmt_t data_o,
  input  logic            stall_i
);
  import sitpd_pkg::*;

  logic             valid_q;
  fmt_t             data_d;
  fmt_t             data_q;
  logic [DIG_W-1:0] lead;
  logic             found;
  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] len_ext;

  always_comb begin
    lead  = '0;
    found = 1'b0;
    for (int j = 0; j < DIGITS - 1; j++) begin
      if (!found && (data_i.bcd[DIGITS-1-j] == '0)) begin
        lead = lead + 1'b1;
      end else begin
        found = 1'b1;
      end
    end
    len     = LEN_W'(DIGITS) - LEN_W'(lead) + LEN_W'(data_i.neg);
    len_ext = CNT_W'(len);
    data_d.bcd   = data_i.bcd;
    data_d.neg   = data_i.neg;
    data_d.lead  = lead;
    data_d.width = data_i.width;
    if (data_i.width > len_ext) begin
      data_d.pad = data_i.width - len_ext;
    end else begin
      data_d.pad = '0;
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/sitpd_serializer.sv =====
// ----------------------------------------------------------------------------
// sitpd_serializer
// Holds one formatted value and emits its characters one per transaction,
// pad spaces first, then the sign and the digits.
// ----------------------------------------------------------------------------
module sitpd_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  sitpd_pkg::fmt_t               data_i,
  output logic                          stall_o,
  output logic                          valid_o,
  output logic [sitpd_pkg::CHAR_W-1:0]  char_out_o,
  output logic                          last_char_o,
  input  logic                          stall_i
);
  import sitpd_pkg::*;

  logic             busy_q;
  logic [CNT_W-1:0] k_q;
  fmt_t             item_q;
  logic             take;
  logic             last;
  logic [CNT_W-1:0] rel;
  logic [CNT_W-1:0] idx;
  logic [DIG_W-1:0] digit;

  assign last    = (k_q + 1'b1) == item_q.width;
  assign take    = busy_q && !stall_i;
  assign stall_o = busy_q && !(take && last);

  always_comb begin
    rel   = k_q - item_q.pad;
    idx   = rel + CNT_W'(item_q.lead) - CNT_W'(item_q.neg);
    digit = item_q.bcd[DIG_W'(DIGITS - 1) - idx[DIG_W-1:0]];
    if (k_q < item_q.pad) begin
      char_out_o = CH_SPACE;
    end else if (item_q.neg && (rel == '0)) begin
      char_out_o = CH_MINUS;
    end else begin
      char_out_o = CH_ZERO + CHAR_W'(digit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (!stall_o) begin
      busy_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      k_q <= '0;
      if (valid_i) begin
        item_q <= data_i;
      end
    end else if (take) begin
      k_q <= k_q + 1'b1;
    end
  end

  assign valid_o     = busy_q;
  assign last_char_o = last;

endmodule

// ===== design/signed_int_to_padded_decimal_top.sv =====
// Throughput: one character per cycle while stall_i is low; a value gives
// field_width characters (capped at MAX_WIDTH), set by the single-character serializer.
// Values of width zero are accepted and produce no characters.
// Reset (rst_ni low, asynchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_top
// Converts a signed 32-bit value into right-justified, fixed-width decimal
// text through a stall-aware pipeline and a character serializer.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_top #(
  parameter int unsigned MAX_WIDTH = sitpd_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [sitpd_pkg::VALUE_W-1:0]  value_i,
  input  logic [sitpd_pkg::FWIDTH_W-1:0] field_width_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic [sitpd_pkg::CHAR_W-1:0]   char_out_o,
  output logic                           last_char_o
);
  import sitpd_pkg::*;

  logic               v0_q;
  dd_t                d0_d;
  dd_t                d0_q;
  logic [CNT_W-1:0]   width_sat;
  logic [VALUE_W-1:0] mag;

  logic [DD_STAGES:0] dv;
  logic [DD_STAGES:0] dstall;
  dd_t                dd [DD_STAGES+1];

  logic               fv;
  logic               fstall;
  fmt_t               fd;

  always_comb begin
    if (CNT_W'(field_width_i) > CNT_W'(MAX_WIDTH)) begin
      width_sat = CNT_W'(MAX_WIDTH);
    end else begin
      width_sat = CNT_W'(field_width_i);
    end
    mag        = value_i[VALUE_W-1] ? (VALUE_W'(0) - value_i) : value_i;
    d0_d.bcd   = '0;
    d0_d.bin   = mag;
    d0_d.neg   = value_i[VALUE_W-1];
    d0_d.width = width_sat;
  end

  assign stall_o = v0_q && dstall[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (!stall_o) begin
      v0_q <= valid_i && (width_sat != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      d0_q <= d0_d;
    end
  end

  assign dv[0] = v0_q;
  assign dd[0] = d0_q;

  for (genvar s = 0; s < DD_STAGES; s++) begin : g_dabble
    sitpd_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[s]),
      .data_i  (dd[s]),
      .stall_o (dstall[s]),
      .valid_o (dv[s+1]),
      .data_o  (dd[s+1]),
      .stall_i (dstall[s+1])
    );
  end

  sitpd_format u_format (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv[DD_STAGES]),
    .data_i  (dd[DD_STAGES]),
    .stall_o (dstall[DD_STAGES]),
    .valid_o (fv),
    .data_o  (fd),
    .stall_i (fstall)
  );

  sitpd_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fv),
    .data_i      (fd),
    .stall_o     (fstall),
    .valid_o     (valid_o),
    .char_out_o  (char_out_o),
    .last_char_o (last_char_o),
    .stall_i     (stall_i)
  );

endmodule

// ===== design/sitpd_checker.sv =====
// ----------------------------------------------------------------------------
// sitpd_checker
// Port-level checks on the character output of the converter.
// ----------------------------------------------------------------------------
module sitpd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         valid_o,
  input logic                         stall_i,
  input logic [sitpd_pkg::CHAR_W-1:0] char_out_o,
  input logic                         last_char_o
);
  import sitpd_pkg::*;

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(char_out_o) && $stable(last_char_o))
    else $error("Output changed while stalled.");

  a_char_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (char_out_o == CH_SPACE) || (char_out_o == CH_MINUS) ||
                ((char_out_o >= CH_ZERO) && (char_out_o <= CH_ZERO + 7'd9)))
    else $error("Character is not a digit, sign or space.");

  a_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !last_char_o |=> valid_o)
    else $error("Gap inside the characters of one value.");

  a_pad_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !last_char_o && (char_out_o != CH_SPACE)
      |=> char_out_o != CH_SPACE)
    else $error("Pad space after text within one value.");

endmodule

bind signed_int_to_padded_decimal_top sitpd_checker u_checker (.*);

// ===== sim/signed_int_to_padded_decimal_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_top_test
// Self-checking testbench for the signed integer to padded decimal converter.
// Each accepted value is turned into its expected right-justified text by a
// local predictor, and every character transaction leaving the block is
// checked in order against it, under random idling on both sides, a long
// receiver hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_top_test;
  import sitpd_pkg::*;

  localparam int unsigned MAX_CHARS    = 32;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                valid_i;
  logic                stall_o;
  logic [VALUE_W-1:0]  value_i;
  logic [FWIDTH_W-1:0] field_width_i;
  logic                valid_o;
  logic                stall_i;
  logic [CHAR_W-1:0]   char_out_o;
  logic                last_char_o;

  text_char_t  pending_chars[$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_done   = 0;
  bit          tx_idle_on   = 1'b0;
  bit          rx_idle_on   = 1'b0;

  signed_int_to_padded_decimal_top #(
    .MAX_WIDTH(MAX_CHARS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .value_i      (value_i),
    .field_width_i(field_width_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .char_out_o   (char_out_o),
    .last_char_o  (last_char_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Builds the decimal text of the value and queues the characters it
  // produces at the given field width.
  task automatic predict_chars(input logic [VALUE_W-1:0] value,
                               input logic [FWIDTH_W-1:0] fwidth);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  text[$];
    int unsigned        w;
    int unsigned        pad;
    text_char_t         c;
    mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
    do begin
      text.push_front(CH_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (value[VALUE_W-1]) begin
      text.push_front(CH_MINUS);
    end
    w = (fwidth > MAX_CHARS) ? MAX_CHARS : fwidth;
    pad = (text.size() < w) ? (w - text.size()) : 0;
    for (int unsigned k = 0; k < w; k++) begin
      c.ch = (k < pad) ? CH_SPACE : text[k - pad];
      c.last = (k + 1 == w);
      pending_chars.push_back(c);
    end
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] value,
                            input logic [FWIDTH_W-1:0] fwidth);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    value_i <= value;
    field_width_i <= fwidth;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    predict_chars(value, fwidth);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    logic [VALUE_W-1:0] v;
    p = 1;
    repeat ($urandom_range(0, 9)) p = p * 10;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 999);
      2: v = p + $urandom_range(0, 2) - 1;
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h8000_0001;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'hFFFF_FFFF;
          default: v = '0;
        endcase
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  function automatic logic [FWIDTH_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FWIDTH_W'($urandom_range(33, 63));
      2, 3: return FWIDTH_W'($urandom_range(12, 32));
      default: return FWIDTH_W'($urandom_range(1, 11));
    endcase
  endfunction

  task automatic test_directed();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_value(32'd0, 6'd1);
    send_value(32'd0, 6'd32);
    send_value(32'h7FFF_FFFF, 6'd10);
    send_value(32'h7FFF_FFFF, 6'd11);
    send_value(32'h7FFF_FFFF, 6'd32);
    send_value(32'h8000_0000, 6'd11);
    send_value(32'h8000_0000, 6'd12);
    send_value(32'h8000_0000, 6'd5);
    send_value(32'h8000_0000, 6'd1);
    send_value(32'hFFFF_FFFF, 6'd1);
    send_value(32'hFFFF_FFFF, 6'd2);
    send_value(32'hFFFF_FFFF, 6'd3);
    send_value(32'd5, 6'd1);
    send_value(-32'sd7, 6'd2);
    send_value(32'd123, 6'd2);
    send_value(32'd12345, 6'd5);
    send_value(32'd42, 6'd0);
    send_value(-32'sd12345, 6'd63);
    send_value(32'd1, 6'd33);
    send_value(32'd1000000000, 6'd40);
    send_value(32'h8000_0001, 6'd0);
    send_value(-32'sd999999999, 6'd20);
  endtask

  // The receiver holds off while values of width 20 to 32 keep coming, so the
  // block fills up and has to stall its input.
  task automatic test_pressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    holds_asked <= holds_asked + 1;
    repeat (16) send_value(pick_value(), FWIDTH_W'($urandom_range(20, 32)));
  endtask

  task automatic test_random();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (45) send_value(pick_value(), pick_width());
  endtask

  task automatic test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (30) send_value(pick_value(), pick_width());
  endtask

  initial begin : receiver
    stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        holds_done++;
        stall_i <= 1'b1;
        for (int unsigned n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        stall_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : char_checker
    text_char_t want;
    if (rst_ni === 1'b1 && valid_o === 1'b1 && stall_i === 1'b0) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b",
                                  char_out_o, last_char_o));
      end else begin
        want = pending_chars.pop_front();
        if (char_out_o !== want.ch) begin
          report_mismatch($sformatf("char_out %h expected %h", char_out_o, want.ch));
        end
        if (last_char_o !== want.last) begin
          report_mismatch($sformatf("last_char %b expected %b", last_char_o, want.last));
        end
      end
    end
  end

  initial begin : run
    rst_ni <= 1'b0;
    valid_i <= 1'b0;
    value_i <= '0;
    field_width_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_pressure();
    test_random();
    test_steady_stream();
    valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== signed_int_to_padded_decimal_top.f =====
design/sitpd_pkg.sv
design/sitpd_dabble_stage.sv
design/sitpd_format.sv
design/sitpd_serializer.sv
design/signed_int_to_padded_decimal_top.sv
design/sitpd_checker.sv
sim/signed_int_to_padded_decimal_top_test.sv
